// ----- rtl/tsa_pkg.sv -----
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, constants and region masks for the two-region slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

  localparam int GLOBAL_SLOTS = 64;
  localparam int TOTAL_SLOTS  = 128;

  localparam int SLOT_W    = 7;
  localparam int ID_LIMIT  = 1 << SLOT_W;
  localparam int ADDR_SLOTS = (TOTAL_SLOTS < ID_LIMIT) ? TOTAL_SLOTS : ID_LIMIT;
  localparam int GLOBAL_END = (GLOBAL_SLOTS < ADDR_SLOTS) ? GLOBAL_SLOTS : ADDR_SLOTS;

  localparam int BIT_W     = 4;
  localparam int WORD_W    = 1 << BIT_W;
  localparam int NUM_WORDS = (ADDR_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef enum logic [2:0] {
    REQ_ALLOC_GLOBAL = 3'd0,
    REQ_ALLOC_AT     = 3'd1,
    REQ_ALLOC_LOCAL  = 3'd2,
    REQ_FREE_GLOBAL  = 3'd3,
    REQ_FREE_LOCAL   = 3'd4,
    REQ_EXISTS       = 3'd5,
    REQ_GET_GLOBAL   = 3'd6,
    REQ_GET_LOCAL    = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OCCUPIED = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [SLOT_W-1:0] slot_id;
  } tsa_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    status_t           status;
    logic              slot_in_use;
  } tsa_rsp_t;

  // First word with a free slot in each region, plus word-written flags
  typedef struct packed {
    logic                 g_found;
    logic [WADDR_W-1:0]   g_word;
    logic                 l_found;
    logic [WADDR_W-1:0]   l_word;
    logic [NUM_WORDS-1:0] word_valid;
  } tsa_pick_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] word;
    logic [WORD_W-1:0]  data;
  } tsa_update_t;

  // Bits of word w that belong to the global region
  function automatic logic [WORD_W-1:0] global_mask(input int w);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = ((w * WORD_W + b) < GLOBAL_END);
    end
    return m;
  endfunction

  // Bits of word w that belong to the local region
  function automatic logic [WORD_W-1:0] local_mask(input int w);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = ((w * WORD_W + b) >= GLOBAL_END) && ((w * WORD_W + b) < ADDR_SLOTS);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tsa_ram.sv -----
// ----------------------------------------------------------------------------
// tsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tsa_summary.sv -----
// ----------------------------------------------------------------------------
// tsa_summary
// Per-word free summaries for both regions and written flags for the bitmap
// words; picks the first word holding a free slot in each region.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_summary (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tsa_pkg::tsa_update_t upd,
  output tsa_pkg::tsa_pick_t        pick
);

  import tsa_pkg::*;

  logic [NUM_WORDS-1:0] gfree;
  logic [NUM_WORDS-1:0] lfree;
  logic [NUM_WORDS-1:0] wvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        gfree[w] <= |global_mask(w);
        lfree[w] <= |local_mask(w);
      end
      wvalid <= '0;
    end else if (upd.en) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (upd.word == WADDR_W'(w)) begin
          gfree[w]  <= |(~upd.data & global_mask(w));
          lfree[w]  <= |(~upd.data & local_mask(w));
          wvalid[w] <= 1'b1;
        end
      end
    end
  end

  // Lowest word wins: scan from the top down
  always_comb begin
    pick = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (gfree[w]) begin
        pick.g_found = 1'b1;
        pick.g_word  = WADDR_W'(w);
      end
      if (lfree[w]) begin
        pick.l_found = 1'b1;
        pick.l_word  = WADDR_W'(w);
      end
    end
    pick.word_valid = wvalid;
  end

endmodule

`default_nettype wire

// ----- rtl/two_region_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// two_region_slot_allocator_unit
// Used-slot bitmap over a global and a local region with first-free
// allocation, named allocation, free and lookup requests.
// ----------------------------------------------------------------------------
// Each request runs through the execute state: busy is high in it, after start
// is taken, while the bitmap word read out of the RAM is checked and written
// back; done pulses with the result in the following cycle, which is also the
// first cycle a new request can be started. The bitmap RAM has registered read
// data, so the word is read when start is taken and written back in the execute
// state. Per-word free flags for each region pick the word to search, so
// first-free allocation reads only the chosen word. The result comes with a done
// pulse that is high for exactly one cycle and is not repeated; the receiver
// must take it when done is high. Reset frees every slot at once with no clearing pass.
`default_nettype none

module two_region_slot_allocator_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tsa_pkg::tsa_req_t req,
  output logic                   done,
  output tsa_pkg::tsa_rsp_t      rsp
);

  import tsa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state;
  tsa_req_t           req_q;
  logic [WADDR_W-1:0] word_q;
  logic               found_q;

  tsa_pick_t          pick;
  tsa_update_t        upd;
  logic               accept;
  logic [WADDR_W-1:0] rd_word;
  logic [SLOT_W-1:0]  id_word;
  logic [WORD_W-1:0]  ram_rdata;

  logic [WORD_W-1:0]  cur_word;
  logic [WORD_W-1:0]  new_word;
  logic [WORD_W-1:0]  search_word;
  logic [BIT_W-1:0]   free_bit;
  logic [BIT_W-1:0]   id_bit;
  logic               cur_bit;
  logic               word_ok;
  logic               is_global;
  logic               is_local;
  logic               in_store;
  tsa_rsp_t           rsp_next;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  // Read address: summary pick for first-free requests, else the named word
  assign id_word = req.slot_id >> BIT_W;
  always_comb begin
    case (req.req_type)
      REQ_ALLOC_GLOBAL: rd_word = pick.g_word;
      REQ_ALLOC_LOCAL:  rd_word = pick.l_word;
      default:          rd_word = id_word[WADDR_W-1:0];
    endcase
  end

  tsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (upd.en),
    .waddr (upd.word),
    .wdata (upd.data),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  tsa_summary u_summary (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .pick (pick)
  );

  // Region checks on the held request
  assign is_global = {1'b0, req_q.slot_id} < (SLOT_W + 1)'(GLOBAL_END);
  assign in_store  = {1'b0, req_q.slot_id} < (SLOT_W + 1)'(ADDR_SLOTS);
  assign is_local  = !is_global && in_store;
  assign id_bit    = req_q.slot_id[BIT_W-1:0];

  // A word never written reads as all free
  always_comb begin
    word_ok = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (word_q == WADDR_W'(w)) begin
        word_ok = pick.word_valid[w];
      end
    end
  end

  assign cur_word = word_ok ? ram_rdata : '0;
  assign cur_bit  = cur_word[id_bit];

  // Restrict the search to the region the request allocates from
  always_comb begin
    if (req_q.req_type == REQ_ALLOC_LOCAL) begin
      search_word = ~cur_word & local_mask(int'(word_q));
    end else begin
      search_word = ~cur_word & global_mask(int'(word_q));
    end
  end

  always_comb begin
    free_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (search_word[b]) begin
        free_bit = BIT_W'(b);
      end
    end
  end

  always_comb begin
    new_word             = cur_word;
    upd.en               = 1'b0;
    rsp_next.result_slot = req_q.slot_id;
    rsp_next.status      = ST_OK;
    rsp_next.slot_in_use = 1'b0;
    case (req_q.req_type)
      REQ_ALLOC_GLOBAL, REQ_ALLOC_LOCAL: begin
        if (found_q) begin
          new_word[free_bit]   = 1'b1;
          upd.en               = 1'b1;
          rsp_next.result_slot = SLOT_W'({word_q, free_bit});
          rsp_next.slot_in_use = 1'b1;
        end else begin
          rsp_next.result_slot = '0;
          rsp_next.status      = ST_FULL;
        end
      end
      REQ_ALLOC_AT: begin
        if (!is_global) begin
          rsp_next.status = ST_RANGE;
        end else if (cur_bit) begin
          rsp_next.status      = ST_OCCUPIED;
          rsp_next.slot_in_use = 1'b1;
        end else begin
          new_word[id_bit]     = 1'b1;
          upd.en               = 1'b1;
          rsp_next.slot_in_use = 1'b1;
        end
      end
      REQ_FREE_GLOBAL: begin
        if (is_global) begin
          new_word[id_bit] = 1'b0;
          upd.en           = 1'b1;
        end else begin
          rsp_next.status = ST_RANGE;
        end
      end
      REQ_FREE_LOCAL: begin
        if (is_local) begin
          new_word[id_bit] = 1'b0;
          upd.en           = 1'b1;
        end else begin
          rsp_next.status = ST_RANGE;
        end
      end
      REQ_EXISTS: begin
        if (in_store) begin
          rsp_next.slot_in_use = cur_bit;
        end else begin
          rsp_next.status = ST_RANGE;
        end
      end
      REQ_GET_GLOBAL: begin
        if (is_global) begin
          rsp_next.slot_in_use = cur_bit;
        end else begin
          rsp_next.status = ST_RANGE;
        end
      end
      default: begin
        if (is_local) begin
          rsp_next.slot_in_use = cur_bit;
        end else begin
          rsp_next.status = ST_RANGE;
        end
      end
    endcase
    // Write back only in the execute cycle
    if (state != S_EXEC) begin
      upd.en = 1'b0;
    end
    upd.word = word_q;
    upd.data = new_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // Hold the request and its chosen word while it executes
    if (accept) begin
      req_q  <= req;
      word_q <= rd_word;
      case (req.req_type)
        REQ_ALLOC_GLOBAL: found_q <= pick.g_found;
        REQ_ALLOC_LOCAL:  found_q <= pick.l_found;
        default:          found_q <= 1'b0;
      endcase
    end
    if (state == S_EXEC) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
